FILE: src/fdem_pkg.sv
// shared types, constants and scaling helpers for the fader deadband effect mapper
// no dependencies; imported by fdem_lane, fdem_merge and the top level
`default_nettype none

package fdem_pkg;

  localparam int NUM_FADERS = 3;
  localparam int LANE_LEFT  = 0;
  localparam int LANE_MID   = 1;
  localparam int LANE_RIGHT = 2;

  localparam int RAW_W  = 16;
  localparam int PCT_W  = 8;
  localparam int PROD_W = 23;  // 65535*100 fits in 23 bits
  localparam int SCL_W  = 13;  // pct*80 at most 8000

  localparam logic [6:0]       PCT_SCALE   = 7'd100;
  localparam logic [16:0]      RAW_FULL    = 17'd65535;
  localparam logic [PCT_W-1:0] LAST_RESET  = 8'hFF;
  localparam logic [8:0]       MOVE_MIN    = 9'd3;
  localparam logic [PCT_W-1:0] PARAM_MIN   = 8'd2;
  localparam logic [4:0]       BASS_OFFSET = 5'd12;

  // reciprocal of 100 in 17 fractional bits, exact for values below 4699
  localparam logic [10:0] RECIP_100 = 11'd1311;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic             moved;
  } lane_res_t;

  typedef struct packed {
    logic              bass_valid;
    logic signed [4:0] bass_db;
    cmd_t              eq_cmd;
    logic              echo_params_valid;
    logic [5:0]        echo_wet;
    logic [6:0]        echo_feedback;
    cmd_t              echo_cmd;
    logic              comp_params_valid;
    logic signed [5:0] comp_threshold_db;
    logic [1:0]        comp_ratio;
    logic [2:0]        comp_makeup_db;
    cmd_t              comp_cmd;
  } result_t;

  // floor(pct*k/100) with pct <= 100 and k <= 80; exact while pct*k stays below 4699
  function automatic logic [6:0] scale_pct(input logic [PCT_W-1:0] pct,
                                           input logic [6:0] k);
    logic [SCL_W-1:0]    v;
    logic [SCL_W+10:0]   p;
    begin
      v = SCL_W'(pct) * SCL_W'(k);
      p = (SCL_W+11)'(v) * (SCL_W+11)'(RECIP_100);
      scale_pct = p[SCL_W+10:17];
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/fader_deadband_effect_mapper.sv
// top level of the fader deadband effect mapper: stream ports, lane control, output register
// depends on fdem_pkg, fdem_lane and fdem_merge
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  s_*     | in        | s_tvalid / s_tready   | s_tdata: three fader readings + flags
//  m_*     | out       | m_tvalid / m_tready   | m_tdata: one effect result word
//  cfg_*   | in        | cfg_valid / cfg_ready | cfg_data: effects master switch
//
// a frame goes through these steps: multiply into the lanes, percentage and deadband check,
// then merge into the output register; the kept percentages close that loop.
// s_tready stays low until the frame reaches the output register, and the merge
// waits while a finished word sits unaccepted on m_*.
// rst (synchronous) clears the kept percentages to 255, the switch and all valids;
// s_tready and cfg_ready are held low while it is asserted.
`default_nettype none

module fader_deadband_effect_mapper
  import fdem_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [15:0] fader_left, [31:16] fader_mid, [47:32] fader_right,
  // [48] other_bands_flat, [49] echo_on, [50] comp_on, [55:51] zero
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [0] bass_valid, [5:1] bass_db, [7:6] eq_cmd, [8] echo_params_valid,
  // [14:9] echo_wet, [21:15] echo_feedback, [23:22] echo_cmd,
  // [24] comp_params_valid, [30:25] comp_threshold_db, [32:31] comp_ratio,
  // [35:33] comp_makeup_db, [37:36] comp_cmd, [39:38] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  logic busy;
  logic p1;
  logic p2;
  logic master_en;
  logic flat;
  logic echo_on;
  logic comp_on;
  logic s_fire;
  logic out_load;

  lane_res_t [NUM_FADERS-1:0]            lane_res;
  logic      [NUM_FADERS-1:0][PCT_W-1:0] last_pct;
  logic      [NUM_FADERS-1:0][RAW_W-1:0] raw;
  result_t                               result;

  assign s_tready  = !busy && !rst;
  assign cfg_ready = !rst;
  assign s_fire    = s_tvalid && s_tready;
  assign out_load  = p2 && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      master_en <= 1'b0;
    end else if (cfg_valid) begin
      master_en <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      p1       <= 1'b0;
      p2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      p1 <= s_fire;
      if (p1) begin
        p2 <= 1'b1;
      end else if (out_load) begin
        p2 <= 1'b0;
      end
      if (s_fire) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // flags ride along with the frame; no new frame enters until this one is out
  always_ff @(posedge clk) begin
    if (s_fire) begin
      flat    <= s_tdata[48];
      echo_on <= s_tdata[49];
      comp_on <= s_tdata[50];
    end
  end

  assign raw[LANE_LEFT]  = s_tdata[15:0];
  assign raw[LANE_MID]   = s_tdata[31:16];
  assign raw[LANE_RIGHT] = s_tdata[47:32];

  for (genvar i = 0; i < NUM_FADERS; i++) begin : g_lane
    fdem_lane u_lane (
      .clk      (clk),
      .load     (s_fire),
      .step     (p1),
      .raw      (raw[i]),
      .last_pct (last_pct[i]),
      .res      (lane_res[i])
    );
  end

  fdem_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .fire      (out_load),
    .master_en (master_en),
    .flat      (flat),
    .echo_on   (echo_on),
    .comp_on   (comp_on),
    .res       (lane_res),
    .last_pct  (last_pct),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00,
                  result.comp_cmd,
                  result.comp_makeup_db,
                  result.comp_ratio,
                  result.comp_threshold_db,
                  result.comp_params_valid,
                  result.echo_cmd,
                  result.echo_feedback,
                  result.echo_wet,
                  result.echo_params_valid,
                  result.eq_cmd,
                  result.bass_db,
                  result.bass_valid};
    end
  end

endmodule

`default_nettype wire

FILE: src/fdem_lane.sv
// one fader lane: raw reading to percentage and deadband check against the kept value
// depends on fdem_pkg
`default_nettype none

module fdem_lane
  import fdem_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [RAW_W-1:0] raw,
  input  wire logic [PCT_W-1:0] last_pct,
  output lane_res_t             res
);

  logic [PROD_W-1:0] prod;
  logic [6:0]        q0;
  logic [16:0]       rem;
  logic [PCT_W-1:0]  pct_next;
  logic [8:0]        diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(raw) * PROD_W'(PCT_SCALE);
    end
  end

  // divide by 2^16-1: quotient by shift, one correction step
  always_comb begin
    q0       = prod[PROD_W-1:16];
    rem      = 17'(prod[15:0]) + 17'(q0);
    pct_next = PCT_W'(q0) + ((rem >= RAW_FULL) ? 8'd1 : 8'd0);
    if (pct_next > last_pct) begin
      diff = 9'(pct_next) - 9'(last_pct);
    end else begin
      diff = 9'(last_pct) - 9'(pct_next);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.pct   <= pct_next;
      res.moved <= (diff >= MOVE_MIN);
    end
  end

endmodule

`default_nettype wire

FILE: src/fdem_merge.sv
// merging stage: drop decision, effect mapping per fader and the kept percentages
// depends on fdem_pkg
`default_nettype none

module fdem_merge
  import fdem_pkg::*;
(
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 fire,
  input  wire logic                                 master_en,
  input  wire logic                                 flat,
  input  wire logic                                 echo_on,
  input  wire logic                                 comp_on,
  input  wire lane_res_t [NUM_FADERS-1:0]           res,
  output logic           [NUM_FADERS-1:0][PCT_W-1:0] last_pct,
  output result_t                                   result
);

  logic [NUM_FADERS-1:0][PCT_W-1:0] last_pct_next;
  logic [6:0] bass_q;
  logic [6:0] th_q;
  logic [6:0] ratio_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FADERS; i++) begin
        last_pct[i] <= LAST_RESET;
      end
    end else if (fire) begin
      last_pct <= last_pct_next;
    end
  end

  always_comb begin
    bass_q  = scale_pct(res[LANE_LEFT].pct, 7'd24);
    th_q    = scale_pct(res[LANE_RIGHT].pct, 7'd18);
    ratio_q = scale_pct(res[LANE_RIGHT].pct, 7'd2);

    result        = '0;
    last_pct_next = last_pct;

    if (res[LANE_LEFT].moved || res[LANE_MID].moved || res[LANE_RIGHT].moved) begin
      if (!master_en) begin
        for (int i = 0; i < NUM_FADERS; i++) begin
          last_pct_next[i] = res[i].pct;
        end
      end else begin
        if (res[LANE_LEFT].moved) begin
          result.bass_valid = 1'b1;
          result.bass_db    = 5'(bass_q) - BASS_OFFSET;
          if (5'(bass_q) != BASS_OFFSET) begin
            result.eq_cmd = CMD_ENABLE;
          end else if (flat) begin
            result.eq_cmd = CMD_DISABLE;
          end
          last_pct_next[LANE_LEFT] = res[LANE_LEFT].pct;
        end

        if (res[LANE_MID].moved) begin
          if (res[LANE_MID].pct > PARAM_MIN) begin
            result.echo_params_valid = 1'b1;
            result.echo_wet      = 6'(scale_pct(res[LANE_MID].pct, 7'd40));
            result.echo_feedback = scale_pct(res[LANE_MID].pct, 7'd80);
            result.echo_cmd      = echo_on ? CMD_NONE : CMD_ENABLE;
          end else begin
            result.echo_cmd      = echo_on ? CMD_DISABLE : CMD_NONE;
          end
          last_pct_next[LANE_MID] = res[LANE_MID].pct;
        end

        if (res[LANE_RIGHT].moved) begin
          if (res[LANE_RIGHT].pct > PARAM_MIN) begin
            result.comp_params_valid = 1'b1;
            result.comp_threshold_db = 6'd0 - 6'(th_q);
            result.comp_ratio        = 2'(ratio_q) + 2'd1;
            result.comp_makeup_db    = 3'(scale_pct(res[LANE_RIGHT].pct, 7'd5));
            result.comp_cmd          = comp_on ? CMD_NONE : CMD_ENABLE;
          end else begin
            result.comp_cmd          = comp_on ? CMD_DISABLE : CMD_NONE;
          end
          last_pct_next[LANE_RIGHT] = res[LANE_RIGHT].pct;
        end
      end
    end
  end

endmodule

`default_nettype wire
